FILE: hw/rtl/gost_block_cipher_modes_core_assert.svh
// ============================================================================
// GOST block cipher core - assertion macros
// Concurrent assertion helpers, clocked and disabled in reset; empty under
// synthesis.
// ============================================================================
`ifndef GOST_BLOCK_CIPHER_MODES_CORE_ASSERT_SVH
`define GOST_BLOCK_CIPHER_MODES_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define GBCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("gbcm assertion failed");
// Next-cycle implication
`define GBCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("gbcm assertion failed");
`else
`define GBCM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GBCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/gbcm_pkg.sv
// ============================================================================
// GOST block cipher core - package
// Widths, register map, S-box table, round function and shared types.
// ============================================================================
package gbcm_pkg;

	localparam int BLK_W  = 64;
	localparam int HALF_W = 32;
	localparam int ADDR_W = 6;
	localparam int RND_W  = 5;

	localparam logic [RND_W-1:0] LAST_RND_FULL = 5'd31;
	localparam logic [RND_W-1:0] LAST_RND_MAC  = 5'd15;

	localparam logic [HALF_W-1:0] CTR_ADD_L = 32'h0101_0104;
	localparam logic [HALF_W-1:0] CTR_ADD_R = 32'h0101_0101;
	localparam logic [HALF_W:0]   CTR_MOD_L = 33'h0_FFFF_FFFF;

	// Modes of use
	typedef enum logic [1:0] {
		MODE_ECB = 2'd0,
		MODE_CTR = 2'd1,
		MODE_CFB = 2'd2,
		MODE_MAC = 2'd3
	} mode_t;

	// Register indexes (byte address = 8 * index)
	typedef enum logic [2:0] {
		REG_MODE  = 3'd0,
		REG_DIR   = 3'd1,
		REG_IV    = 3'd2,
		REG_KEY0  = 3'd3,
		REG_KEY1  = 3'd4,
		REG_KEY2  = 3'd5,
		REG_KEY3  = 3'd6
	} reg_idx_t;

	// CryptoPro-A S-box, one row per nibble; entry v sits at bits [4v+3:4v]
	localparam logic [63:0] SBOX_ROW [8] = '{
		64'h5D0CFE4A71B82369,
		64'h9170A5FC8D3B264E,
		64'h1D4BC6250FA89E73,
		64'h658F4B20931DCA7E,
		64'h6A7C324E0FD8915B,
		64'h6EF84957B021CDA3,
		64'hEB3F54C806A792D1,
		64'h4D7193268EC05FAB
	};

	typedef struct packed {
		mode_t                 mode;
		logic                  dir;
		logic [BLK_W-1:0]      iv;
		logic [3:0][BLK_W-1:0] key_pair;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic             load;
		logic             step;
		logic             round_en;
		logic             commit;
		logic             emit;
		logic [RND_W-1:0] rnd;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic first;
		logic last;
	} sts_t;

	// Add subkey, substitute each nibble, rotate left by 11
	function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] x,
	                                               input logic [HALF_W-1:0] k);
		logic [HALF_W-1:0] s;
		logic [HALF_W-1:0] r;
		s = x + k;
		for (int i = 0; i < 8; i++) begin
			r[4*i +: 4] = SBOX_ROW[i][{s[4*i +: 4], 2'b00} +: 4];
		end
		return {r[HALF_W-12:0], r[HALF_W-1:HALF_W-11]};
	endfunction

	// Key word index for a round: encrypt K0..K7 x3 then K7..K0,
	// decrypt K0..K7 then K7..K0 x3
	function automatic logic [2:0] key_index(input logic [RND_W-1:0] j,
	                                         input logic decrypt);
		logic rev;
		rev = decrypt ? (j[4:3] != 2'b00) : (j[4:3] == 2'b11);
		return rev ? ~j[2:0] : j[2:0];
	endfunction

	// Step the gamma counter: left mod 2^32-1, right mod 2^32
	function automatic logic [BLK_W-1:0] ctr_step(input logic [BLK_W-1:0] c);
		logic [HALF_W:0] l;
		l = {1'b0, c[BLK_W-1:HALF_W]} + {1'b0, CTR_ADD_L};
		if (l >= CTR_MOD_L) begin
			l = l - CTR_MOD_L;
		end
		return {l[HALF_W-1:0], c[HALF_W-1:0] + CTR_ADD_R};
	endfunction

endpackage

FILE: hw/rtl/gbcm_in_if.sv
// ============================================================================
// GOST block cipher core - input channel
// Valid/ready channel carrying one data block and its chaining flags.
// ============================================================================
interface gbcm_in_if;
	logic                       valid;
	logic                       ready;
	logic [gbcm_pkg::BLK_W-1:0] data_block;
	logic                       first_block;
	logic                       last_block;

	modport source (output valid, data_block, first_block, last_block, input ready);
	modport sink (input valid, data_block, first_block, last_block, output ready);
endinterface

FILE: hw/rtl/gbcm_out_if.sv
// ============================================================================
// GOST block cipher core - output channel
// Valid/ready channel carrying a transformed block or a MAC tag.
// ============================================================================
interface gbcm_out_if;
	logic                       valid;
	logic                       ready;
	logic [gbcm_pkg::BLK_W-1:0] out_block;
	logic                       is_tag;

	modport source (output valid, out_block, is_tag, input ready);
	modport sink (input valid, out_block, is_tag, output ready);
endinterface

FILE: hw/rtl/gost_block_cipher_modes_core.sv
// ============================================================================
// GOST block cipher core - top level
// GOST 28147-89 cipher with ECB, counter gamma, CFB and MAC modes.
//
//   channel   kind          payload
//   in_ch     valid/ready   data_block[63:0], first_block, last_block
//   out_ch    valid/ready   out_block[63:0], is_tag
//   apb       psel/penable  paddr[5:0], pwdata/prdata[63:0], register i at 8*i
//
// One Feistel round per cycle through a single round unit. ECB and CFB accept
// an item, run 32 rounds and commit; counter mode steps the counter before the
// rounds, and on a first block first encrypts the init vector. MAC runs the short round sequence and then commits.
// An item is accepted only while the core is idle; a finished result waits in
// the output register, and the next item may run meanwhile, holding at commit
// until the register drains. Reset clears all chaining state to zero.
// ============================================================================
`include "gost_block_cipher_modes_core_assert.svh"

module gost_block_cipher_modes_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gbcm_pkg::ADDR_W-1:0] paddr,
	input  logic [gbcm_pkg::BLK_W-1:0]  pwdata,
	output logic [gbcm_pkg::BLK_W-1:0]  prdata,
	output logic                        pready,
	gbcm_in_if.sink                     in_ch,
	gbcm_out_if.source                  out_ch
);

	gbcm_pkg::cfg_t cfg;
	gbcm_pkg::cmd_t cmd;
	gbcm_pkg::sts_t sts;

	gbcm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gbcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (cfg.mode),
		.first_in  (in_ch.first_block),
		.sts       (sts),
		.cmd       (cmd),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready)
	);

	gbcm_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.data_block  (in_ch.data_block),
		.first_block (in_ch.first_block),
		.last_block  (in_ch.last_block),
		.out_block   (out_ch.out_block),
		.is_tag      (out_ch.is_tag)
	);

	// An accepted item always keeps the core busy for the next cycle
	`GBCM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
	// A result is never committed over one still waiting
	`GBCM_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.commit && cmd.emit, !out_ch.valid || out_ch.ready)
	// Rounds never run while the input side is open
	`GBCM_ASSERT_NOW(a_round_when_busy, clk, arst_n, cmd.round_en || cmd.step, !in_ch.ready)

endmodule

FILE: hw/rtl/gbcm_regs.sv
// ============================================================================
// GOST block cipher core - configuration registers
// APB-style register file: mode, direction, init vector and four key pairs.
// ============================================================================
module gbcm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gbcm_pkg::ADDR_W-1:0] paddr,
	input  logic [gbcm_pkg::BLK_W-1:0]  pwdata,
	output logic [gbcm_pkg::BLK_W-1:0]  prdata,
	output logic                        pready,
	output gbcm_pkg::cfg_t              cfg
);

	gbcm_pkg::cfg_t     cfg_q;
	gbcm_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = gbcm_pkg::reg_idx_t'(paddr[gbcm_pkg::ADDR_W-1:3]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				gbcm_pkg::REG_MODE: cfg_q.mode        <= gbcm_pkg::mode_t'(pwdata[1:0]);
				gbcm_pkg::REG_DIR:  cfg_q.dir         <= pwdata[0];
				gbcm_pkg::REG_IV:   cfg_q.iv          <= pwdata;
				gbcm_pkg::REG_KEY0: cfg_q.key_pair[0] <= pwdata;
				gbcm_pkg::REG_KEY1: cfg_q.key_pair[1] <= pwdata;
				gbcm_pkg::REG_KEY2: cfg_q.key_pair[2] <= pwdata;
				gbcm_pkg::REG_KEY3: cfg_q.key_pair[3] <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (idx)
			gbcm_pkg::REG_MODE: prdata = {{(gbcm_pkg::BLK_W-2){1'b0}}, cfg_q.mode};
			gbcm_pkg::REG_DIR:  prdata = {{(gbcm_pkg::BLK_W-1){1'b0}}, cfg_q.dir};
			gbcm_pkg::REG_IV:   prdata = cfg_q.iv;
			gbcm_pkg::REG_KEY0: prdata = cfg_q.key_pair[0];
			gbcm_pkg::REG_KEY1: prdata = cfg_q.key_pair[1];
			gbcm_pkg::REG_KEY2: prdata = cfg_q.key_pair[2];
			gbcm_pkg::REG_KEY3: prdata = cfg_q.key_pair[3];
			default:            prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/gbcm_datapath.sv
// ============================================================================
// GOST block cipher core - datapath
// Feistel round registers, gamma counter, feedback, MAC chain and the
// output register.
// ============================================================================
module gbcm_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gbcm_pkg::cfg_t             cfg,
	input  gbcm_pkg::cmd_t             cmd,
	output gbcm_pkg::sts_t             sts,
	input  logic [gbcm_pkg::BLK_W-1:0] data_block,
	input  logic                       first_block,
	input  logic                       last_block,
	output logic [gbcm_pkg::BLK_W-1:0] out_block,
	output logic                       is_tag
);

	localparam int HW = gbcm_pkg::HALF_W;
	localparam int BW = gbcm_pkg::BLK_W;

	logic [HW-1:0] hl_q, hr_q;
	logic [BW-1:0] ctr_q, fb_q, mac_q;
	logic [BW-1:0] data_q;
	logic          first_q, last_q;
	logic [BW-1:0] out_q;
	logic          tag_q;

	logic [2:0]    kidx;
	logic [BW-1:0] kpair;
	logic [HW-1:0] subkey;
	logic [HW-1:0] f_out;
	logic [BW-1:0] swapped;
	logic [BW-1:0] xored;
	logic [BW-1:0] step_src;
	logic [BW-1:0] stepped;

	// Subkey for the current round; ECB alone honours direction
	assign kidx   = gbcm_pkg::key_index(cmd.rnd,
		(cfg.mode == gbcm_pkg::MODE_ECB) & cfg.dir);
	assign kpair  = cfg.key_pair[kidx[2:1]];
	assign subkey = kidx[0] ? kpair[HW-1:0] : kpair[BW-1:HW];
	assign f_out  = gbcm_pkg::round_fn(hl_q, subkey);

	assign swapped  = {hr_q, hl_q};
	assign xored    = data_q ^ swapped;
	assign step_src = first_q ? swapped : ctr_q;
	assign stepped  = gbcm_pkg::ctr_step(step_src);

	// Round registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_q <= '0;
			hr_q <= '0;
		end else if (cmd.load) begin
			unique case (cfg.mode)
				gbcm_pkg::MODE_ECB: {hl_q, hr_q} <= data_block;
				gbcm_pkg::MODE_CTR: {hl_q, hr_q} <= cfg.iv;
				gbcm_pkg::MODE_CFB: {hl_q, hr_q} <= first_block ? cfg.iv : fb_q;
				gbcm_pkg::MODE_MAC: {hl_q, hr_q} <= (first_block ? '0 : mac_q) ^ data_block;
				default: ;
			endcase
		end else if (cmd.step) begin
			{hl_q, hr_q} <= stepped;
		end else if (cmd.round_en) begin
			hl_q <= hr_q ^ f_out;
			hr_q <= hl_q;
		end
	end

	// Chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			fb_q  <= '0;
			mac_q <= '0;
		end else begin
			if (cmd.step) begin
				ctr_q <= stepped;
			end
			if (cmd.commit && cfg.mode == gbcm_pkg::MODE_CFB) begin
				fb_q <= cfg.dir ? data_q : xored;
			end
			if (cmd.commit && cfg.mode == gbcm_pkg::MODE_MAC) begin
				mac_q <= {hl_q, hr_q};
			end
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_q  <= data_block;
			first_q <= first_block;
			last_q  <= last_block;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.commit && cmd.emit) begin
			unique case (cfg.mode)
				gbcm_pkg::MODE_ECB: out_q <= swapped;
				gbcm_pkg::MODE_CTR: out_q <= xored;
				gbcm_pkg::MODE_CFB: out_q <= xored;
				gbcm_pkg::MODE_MAC: out_q <= swapped;
				default: ;
			endcase
			tag_q <= (cfg.mode == gbcm_pkg::MODE_MAC);
		end
	end

	assign out_block = out_q;
	assign is_tag    = tag_q;
	assign sts.first = first_q;
	assign sts.last  = last_q;

endmodule

FILE: hw/rtl/gbcm_ctrl.sv
// ============================================================================
// GOST block cipher core - controller
// Sequences load, counter setup, rounds and commit of one item; owns the
// handshakes.
// ============================================================================
module gbcm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  gbcm_pkg::mode_t  mode,
	input  logic             first_in,
	input  gbcm_pkg::sts_t   sts,
	output gbcm_pkg::cmd_t   cmd,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_INIT = 5'b00010,
		S_STEP = 5'b00100,
		S_RUN  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t                     state_q, state_d;
	logic [gbcm_pkg::RND_W-1:0] rnd_q, rnd_d;
	logic                       out_valid_q;
	logic [gbcm_pkg::RND_W-1:0] last_rnd;
	logic                       out_free;
	logic                       emit;

	assign out_free = ~out_valid_q | out_ready;
	assign emit     = (mode != gbcm_pkg::MODE_MAC) | sts.last;
	assign last_rnd = (mode == gbcm_pkg::MODE_MAC) ? gbcm_pkg::LAST_RND_MAC
	                                               : gbcm_pkg::LAST_RND_FULL;

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		rnd_d        = rnd_q;
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.step     = 1'b0;
		cmd.round_en = 1'b0;
		cmd.commit   = 1'b0;
		cmd.emit     = emit;
		cmd.rnd      = rnd_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					rnd_d    = '0;
					// The first flag of the item being accepted comes straight off the port
					if (mode == gbcm_pkg::MODE_CTR) begin
						state_d = first_in ? S_INIT : S_STEP;
					end else begin
						state_d = S_RUN;
					end
				end
			end
			S_INIT: begin
				cmd.round_en = 1'b1;
				if (rnd_q == gbcm_pkg::LAST_RND_FULL) begin
					rnd_d   = '0;
					state_d = S_STEP;
				end else begin
					rnd_d = rnd_q + 1'b1;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_RUN;
			end
			S_RUN: begin
				cmd.round_en = 1'b1;
				if (rnd_q == last_rnd) begin
					rnd_d   = '0;
					state_d = S_FIN;
				end else begin
					rnd_d = rnd_q + 1'b1;
				end
			end
			S_FIN: begin
				if (!emit || out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
		end
	end

	// Output valid: set on a committed result that is emitted, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: bench/gbcm_checker.sv
// ----------------------------------------------------------------------------
// GOST block cipher core - result checker
// Watches the register port and both block channels, predicts every result
// of the cipher modes (ECB, counter gamma, CFB, MAC) from its own copy of the
// registers and the chaining state, and compares each output item with the
// oldest prediction. Reports the failure count and the items still owed.
// ----------------------------------------------------------------------------
module gbcm_checker
	import gbcm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [BLK_W-1:0]  pwdata,
	input  logic              pready,
	gbcm_in_if                in_mon,
	gbcm_out_if               out_mon,
	output int                fail_count,
	output int                blocks_owed
);

	// CryptoPro-A substitution, one row per nibble position
	localparam int SUBST [8][16] = '{
		'{ 9,  6,  3,  2,  8, 11,  1,  7, 10,  4, 14, 15, 12,  0, 13,  5},
		'{14,  4,  6,  2, 11,  3, 13,  8, 12, 15,  5, 10,  0,  7,  1,  9},
		'{ 3,  7, 14,  9,  8, 10, 15,  0,  5,  2,  6, 12, 11,  4, 13,  1},
		'{14,  7, 10, 12, 13,  1,  3,  9,  0,  2, 11,  4, 15,  8,  5,  6},
		'{11,  5,  1,  9,  8, 13, 15,  0, 14,  4,  2,  3, 12,  7, 10,  6},
		'{ 3, 10, 13, 12,  1,  2,  0, 11,  7,  5,  9,  4,  8, 15, 14,  6},
		'{ 1, 13,  2,  9,  7, 10,  6,  0,  8, 12,  4,  5, 15,  3, 11, 14},
		'{11, 10, 15,  5,  0, 12, 14,  8,  6,  2,  3,  9,  1,  7, 13,  4}
	};

	localparam logic [HALF_W:0] GAMMA_MOD_L = 33'h0_FFFF_FFFF;

	typedef struct packed {
		logic [BLK_W-1:0] blk;
		logic             tag;
	} tag_block_t;

	// Shadow registers
	mode_t            cfg_mode;
	logic             cfg_decrypt;
	logic [BLK_W-1:0] cfg_iv;
	logic [BLK_W-1:0] key_pairs [4];

	// Chaining state
	logic [BLK_W-1:0] feedback;
	logic [BLK_W-1:0] gamma_ctr;
	logic [BLK_W-1:0] mac_acc;

	tag_block_t owed_q [$];

	function automatic logic [HALF_W-1:0] subkey_for(input int unsigned j, input logic dec);
		int unsigned w;
		logic [BLK_W-1:0] pair;
		if (!dec) begin
			w = (j < 24) ? j % 8 : 7 - j % 8;
		end else begin
			w = (j < 8) ? j : 7 - j % 8;
		end
		pair = key_pairs[w / 2];
		return (w % 2) ? pair[HALF_W-1:0] : pair[BLK_W-1:HALF_W];
	endfunction

	// Add subkey, substitute nibbles, rotate left by 11
	function automatic logic [HALF_W-1:0] mix(input logic [HALF_W-1:0] x,
	                                          input logic [HALF_W-1:0] k);
		logic [HALF_W-1:0] s;
		logic [HALF_W-1:0] r;
		s = x + k;
		for (int i = 0; i < 8; i++) begin
			r[4*i +: 4] = 4'(SUBST[i][s[4*i +: 4]]);
		end
		return {r[20:0], r[31:21]};
	endfunction

	// Feistel rounds without the closing swap
	function automatic logic [BLK_W-1:0] feistel(input logic [BLK_W-1:0] blk,
	                                             input int unsigned rounds,
	                                             input logic dec);
		logic [HALF_W-1:0] l;
		logic [HALF_W-1:0] r;
		logic [HALF_W-1:0] nl;
		l = blk[BLK_W-1:HALF_W];
		r = blk[HALF_W-1:0];
		for (int unsigned j = 0; j < rounds; j++) begin
			nl = r ^ mix(l, subkey_for(j, dec));
			r = l;
			l = nl;
		end
		return {l, r};
	endfunction

	function automatic logic [BLK_W-1:0] encipher(input logic [BLK_W-1:0] blk,
	                                              input logic dec);
		logic [BLK_W-1:0] v;
		v = feistel(blk, 32, dec);
		return {v[HALF_W-1:0], v[BLK_W-1:HALF_W]};
	endfunction

	always @(posedge clk) begin
		tag_block_t       want;
		logic [BLK_W-1:0] res;
		logic [HALF_W:0]  sum;
		if (!arst_n) begin
			cfg_mode = MODE_ECB;
			cfg_decrypt = 1'b0;
			cfg_iv = '0;
			for (int p = 0; p < 4; p++) begin
				key_pairs[p] = '0;
			end
			feedback = '0;
			gamma_ctr = '0;
			mac_acc = '0;
			owed_q.delete();
			blocks_owed = 0;
		end else begin
			// Compare the output item with the oldest prediction
			if (out_mon.valid && out_mon.ready) begin
				if (owed_q.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual out_block %h is_tag %b",
					         $time, out_mon.out_block, out_mon.is_tag);
					fail_count++;
				end else begin
					want = owed_q.pop_front();
					if (out_mon.out_block !== want.blk) begin
						$display("%0t: out_block mismatch, expected %h actual %h",
						         $time, want.blk, out_mon.out_block);
						fail_count++;
					end
					if (out_mon.is_tag !== want.tag) begin
						$display("%0t: is_tag mismatch, expected %b actual %b",
						         $time, want.tag, out_mon.is_tag);
						fail_count++;
					end
				end
			end

			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:3]))
					REG_MODE: cfg_mode = mode_t'(pwdata[1:0]);
					REG_DIR:  cfg_decrypt = pwdata[0];
					REG_IV:   cfg_iv = pwdata;
					REG_KEY0: key_pairs[0] = pwdata;
					REG_KEY1: key_pairs[1] = pwdata;
					REG_KEY2: key_pairs[2] = pwdata;
					REG_KEY3: key_pairs[3] = pwdata;
					default: ;
				endcase
			end

			// Predict the result of an accepted item
			if (in_mon.valid && in_mon.ready) begin
				case (cfg_mode)
					MODE_ECB: begin
						owed_q.push_back('{encipher(in_mon.data_block, cfg_decrypt), 1'b0});
					end
					MODE_CTR: begin
						if (in_mon.first_block) begin
							gamma_ctr = encipher(cfg_iv, 1'b0);
						end
						// left half wraps modulo 2^32-1, right half modulo 2^32
						sum = {1'b0, gamma_ctr[BLK_W-1:HALF_W]} + 33'h0_0101_0104;
						if (sum >= GAMMA_MOD_L) begin
							sum = sum - GAMMA_MOD_L;
						end
						gamma_ctr = {sum[HALF_W-1:0], gamma_ctr[HALF_W-1:0] + 32'h0101_0101};
						res = in_mon.data_block ^ encipher(gamma_ctr, 1'b0);
						owed_q.push_back('{res, 1'b0});
					end
					MODE_CFB: begin
						if (in_mon.first_block) begin
							feedback = cfg_iv;
						end
						res = in_mon.data_block ^ encipher(feedback, 1'b0);
						feedback = cfg_decrypt ? in_mon.data_block : res;
						owed_q.push_back('{res, 1'b0});
					end
					default: begin
						if (in_mon.first_block) begin
							mac_acc = '0;
						end
						mac_acc = feistel(mac_acc ^ in_mon.data_block, 16, 1'b0);
						if (in_mon.last_block) begin
							owed_q.push_back('{{mac_acc[HALF_W-1:0], mac_acc[BLK_W-1:HALF_W]},
							                   1'b1});
						end
					end
				endcase
			end

			blocks_owed = owed_q.size();
		end
	end

endmodule

FILE: bench/tb_gost_block_cipher_modes_core.sv
// ----------------------------------------------------------------------------
// GOST block cipher core - testbench
// Programs the registers between phases over the APB port, then streams
// blocks through every mode and direction: a directed opening on chaining
// from reset, field extremes and single-block MAC tags, followed by random
// chained runs with broken runs mixed in. Both channels idle at random.
// Results are checked by gbcm_checker.
// ----------------------------------------------------------------------------
module tb_gost_block_cipher_modes_core;
	import gbcm_pkg::*;

	localparam int PHASES       = 11;
	localparam int PHASE_ITEMS  = 36;
	localparam int SETTLE_TICKS = 80;
	localparam int QUIET_LIMIT  = 2000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [BLK_W-1:0]  pwdata;
	logic [BLK_W-1:0]  prdata;
	logic              pready;

	int fail_count;
	int blocks_owed;
	int gap_pct;
	int stall_pct;
	int quiet_ticks;

	gbcm_in_if  blk_in ();
	gbcm_out_if blk_out ();

	gost_block_cipher_modes_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (blk_in),
		.out_ch  (blk_out)
	);

	gbcm_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.in_mon      (blk_in),
		.out_mon     (blk_out),
		.fail_count  (fail_count),
		.blocks_owed (blocks_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the output side in random bursts
	initial begin
		int hold;
		hold = 0;
		blk_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				blk_out.ready = 1'b0;
			end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				hold = $urandom_range(1, 4) - 1;
				blk_out.ready = 1'b0;
			end else begin
				blk_out.ready = 1'b1;
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((blk_in.valid && blk_in.ready) || (blk_out.valid && blk_out.ready) ||
		    (psel && penable && pwrite && pready)) begin
			quiet_ticks <= 0;
		end else begin
			quiet_ticks <= quiet_ticks + 1;
		end
		if (quiet_ticks >= QUIET_LIMIT) begin
			$display("tb_gost_block_cipher_modes_core: FAIL");
			$finish;
		end
	end

	function automatic logic [BLK_W-1:0] rand_block();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Setup and access phase; enter and leave on a falling edge
	task automatic apb_write(input reg_idx_t idx, input logic [BLK_W-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Hold the sender until every owed item has arrived
	task automatic wait_owed();
		blk_in.valid = 1'b0;
		while (blocks_owed != 0) @(negedge clk);
	endtask

	// Drain, let a tagless MAC block finish, then program all registers
	task automatic configure(input mode_t m, input logic dir, input logic [BLK_W-1:0] iv,
	                         input logic [3:0][BLK_W-1:0] keys);
		wait_owed();
		repeat (SETTLE_TICKS) @(negedge clk);
		apb_write(REG_MODE, BLK_W'(m));
		apb_write(REG_DIR, BLK_W'(dir));
		apb_write(REG_IV, iv);
		apb_write(REG_KEY0, keys[0]);
		apb_write(REG_KEY1, keys[1]);
		apb_write(REG_KEY2, keys[2]);
		apb_write(REG_KEY3, keys[3]);
	endtask

	// Offer one item and hold it until accepted; valid stays high on return
	task automatic send_block(input logic [BLK_W-1:0] blk, input logic first,
	                          input logic last);
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			blk_in.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		blk_in.valid = 1'b1;
		blk_in.data_block = blk;
		blk_in.first_block = first;
		blk_in.last_block = last;
		do @(posedge clk); while (!blk_in.ready);
		@(negedge clk);
	endtask

	initial begin
		logic [3:0][BLK_W-1:0] keys;
		mode_t                 m;
		logic                  dir;
		logic [BLK_W-1:0]      iv;
		int                    sent;
		int                    run_len;
		bit                    calm;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		blk_in.valid = 1'b0;
		blk_in.data_block = '0;
		blk_in.first_block = 1'b0;
		blk_in.last_block = 1'b0;
		gap_pct = 20;
		stall_pct = 20;
		quiet_ticks = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < 4; p++) begin
			keys[p] = {$urandom, $urandom};
		end

		// Chaining with no start: counter, feedback and MAC run from zero
		configure(MODE_CTR, 1'b0, rand_block(), keys);
		send_block('0, 1'b0, 1'b0);
		send_block('1, 1'b0, 1'b0);
		configure(MODE_CFB, 1'b0, rand_block(), keys);
		send_block('0, 1'b0, 1'b0);
		send_block('1, 1'b0, 1'b0);
		configure(MODE_MAC, 1'b0, rand_block(), keys);
		send_block('1, 1'b0, 1'b0);
		send_block('0, 1'b0, 1'b1);

		// Field extremes in both directions of ECB
		configure(MODE_ECB, 1'b0, '1, keys);
		send_block('0, 1'b0, 1'b0);
		send_block('1, 1'b1, 1'b1);
		send_block(64'h8000_0000_0000_0001, 1'b0, 1'b1);
		send_block(64'hFFFF_FFFF_0000_0000, 1'b1, 1'b0);
		configure(MODE_ECB, 1'b1, '0, keys);
		send_block('0, 1'b0, 1'b0);
		send_block('1, 1'b1, 1'b1);

		// Restarted chains; direction must not matter for the counter
		configure(MODE_CTR, 1'b1, '0, keys);
		send_block(rand_block(), 1'b1, 1'b0);
		send_block(rand_block(), 1'b0, 1'b0);
		send_block(rand_block(), 1'b1, 1'b1);
		configure(MODE_CFB, 1'b0, '1, keys);
		send_block(rand_block(), 1'b1, 1'b0);
		send_block(rand_block(), 1'b0, 1'b1);
		configure(MODE_CFB, 1'b1, rand_block(), keys);
		send_block(rand_block(), 1'b1, 1'b0);
		send_block(rand_block(), 1'b0, 1'b0);

		// Single-block tag, then a three-block tag
		configure(MODE_MAC, 1'b1, rand_block(), keys);
		send_block(rand_block(), 1'b1, 1'b1);
		send_block(rand_block(), 1'b1, 1'b0);
		send_block(rand_block(), 1'b0, 1'b0);
		send_block(rand_block(), 1'b0, 1'b1);

		// Random phases: every mode in both directions, then random settings
		for (int phase = 0; phase < PHASES; phase++) begin
			calm = (phase == PHASES - 1);
			m = (phase < 8) ? mode_t'(phase % 4) : mode_t'($urandom_range(0, 3));
			dir = (phase < 8) ? logic'(phase / 4) : logic'($urandom_range(0, 1));
			for (int p = 0; p < 4; p++) begin
				keys[p] = (phase == 0) ? '0 : (phase == 1) ? '1 : {$urandom, $urandom};
			end
			iv = (phase == 2) ? '0 : (phase == 3) ? '1 : rand_block();
			configure(m, dir, iv, keys);
			gap_pct = calm ? 0 : (phase % 3) * 25;
			stall_pct = calm ? 0 : ((phase + 1) % 3) * 25;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					// stray flags outside a well-formed run
					send_block(rand_block(), 1'($urandom_range(0, 1)),
					           1'($urandom_range(0, 1)));
					sent++;
				end else begin
					if (!calm && $urandom_range(0, 11) == 0) begin
						wait_owed();
					end
					run_len = $urandom_range(1, 6);
					for (int k = 0; k < run_len; k++) begin
						send_block(rand_block(), k == 0, k == run_len - 1);
					end
					sent += run_len;
				end
			end
		end

		// Drain and give the verdict
		wait_owed();
		repeat (SETTLE_TICKS) @(negedge clk);
		if (fail_count == 0 && blocks_owed == 0) begin
			$display("tb_gost_block_cipher_modes_core: PASS");
		end else begin
			$display("tb_gost_block_cipher_modes_core: FAIL");
		end
		$finish;
	end

endmodule

FILE: gost_block_cipher_modes_core.f
+incdir+hw/rtl
hw/rtl/gbcm_pkg.sv
hw/rtl/gbcm_in_if.sv
hw/rtl/gbcm_out_if.sv
hw/rtl/gbcm_regs.sv
hw/rtl/gbcm_datapath.sv
hw/rtl/gbcm_ctrl.sv
hw/rtl/gost_block_cipher_modes_core.sv
bench/gbcm_checker.sv
bench/tb_gost_block_cipher_modes_core.sv
